/* src/hpd_pkg.sv */
// ----------------------------------------------------------------------------
// hpd_pkg
// shared types and codes for the hci h4 packet deframer
// ----------------------------------------------------------------------------
package hpd_pkg;

    localparam logic [7:0] IND_ACL   = 8'h02;
    localparam logic [7:0] IND_SCO   = 8'h03;
    localparam logic [7:0] IND_EVENT = 8'h04;

    localparam logic [1:0] ROLE_INDICATOR = 2'd0;
    localparam logic [1:0] ROLE_HEADER    = 2'd1;
    localparam logic [1:0] ROLE_PAYLOAD   = 2'd2;

    localparam logic [1:0] KIND_EVENT = 2'd0;
    localparam logic [1:0] KIND_ACL   = 2'd1;
    localparam logic [1:0] KIND_SCO   = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_IND   = 2'd1;
    localparam logic [1:0] STATUS_TOO_LONG  = 2'd2;

    localparam logic [15:0] MAX_PACKET_RESET = 16'd1024;
    localparam logic [16:0] ACL_HEADER_BYTES = 17'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic [1:0] byte_role;
        logic [1:0] packet_kind;
        logic       end_of_packet;
        logic [1:0] status;
    } result_t;

endpackage

/* src/hpd_if.sv */
// ----------------------------------------------------------------------------
// hpd interfaces
// valid/ready channels for received bytes, framed results and configuration
// ----------------------------------------------------------------------------
interface hpd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hpd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic [1:0] byte_role;
    logic [1:0] packet_kind;
    logic       end_of_packet;
    logic [1:0] status;

    modport source (output valid, output data_byte, output byte_role, output packet_kind,
                    output end_of_packet, output status, input ready);
    modport sink   (input valid, input data_byte, input byte_role, input packet_kind,
                    input end_of_packet, input status, output ready);
endinterface

interface hpd_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] max_packet_bytes;

    modport source (output valid, output max_packet_bytes, input ready);
    modport sink   (input valid, input max_packet_bytes, output ready);
endinterface

/* src/hpd_front.sv */
// ----------------------------------------------------------------------------
// hpd_front
// byte framing state machine: classifies each word and pushes its result
// ----------------------------------------------------------------------------
module hpd_front
    import hpd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [7:0]  rx_byte,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,
    input  logic        push_ready,
    output logic        push_valid,
    output result_t     push_data
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_PAYLOAD
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  kind_reg, kind_next;
    logic [2:0]  hdr_idx_reg, hdr_idx_next;
    logic [15:0] left_reg, left_next;
    logic [7:0]  len_lo_reg, len_lo_next;
    logic [15:0] max_reg;
    result_t     res;
    logic [2:0]  hdr_last;
    logic [15:0] len;
    logic [16:0] total;
    logic [15:0] left_dec;
    logic        accept;

    assign accept     = in_valid && push_ready;
    assign push_valid = in_valid;
    assign push_data  = res;

    always_comb
    begin
        phase_next   = phase_reg;
        kind_next    = kind_reg;
        hdr_idx_next = hdr_idx_reg;
        left_next    = left_reg;
        len_lo_next  = len_lo_reg;
        res.data_byte     = rx_byte;
        res.byte_role     = ROLE_INDICATOR;
        res.packet_kind   = KIND_EVENT;
        res.end_of_packet = 1'b0;
        res.status        = STATUS_OK;
        hdr_last = (kind_reg == KIND_ACL) ? 3'd3 : (kind_reg == KIND_SCO) ? 3'd2 : 3'd1;
        len      = (kind_reg == KIND_ACL) ? {rx_byte, len_lo_reg} : {8'd0, rx_byte};
        total    = ACL_HEADER_BYTES + {1'b0, len};
        left_dec = left_reg - 16'd1;
        case (phase_reg)
            PH_HEADER:
            begin
                res.byte_role   = ROLE_HEADER;
                res.packet_kind = kind_reg;
                if (kind_reg == KIND_ACL && hdr_idx_reg == 3'd2)
                begin
                    len_lo_next = rx_byte;
                end
                if (hdr_idx_reg >= hdr_last)
                begin
                    hdr_idx_next = 3'd0;
                    if (kind_reg == KIND_ACL && total > {1'b0, max_reg})
                    begin
                        res.status = STATUS_TOO_LONG;
                        phase_next = PH_IDLE;
                    end
                    else if (len == 16'd0)
                    begin
                        res.end_of_packet = 1'b1;
                        phase_next        = PH_IDLE;
                    end
                    else
                    begin
                        left_next  = len;
                        phase_next = PH_PAYLOAD;
                    end
                end
                else
                begin
                    hdr_idx_next = hdr_idx_reg + 3'd1;
                end
            end
            PH_PAYLOAD:
            begin
                res.byte_role   = ROLE_PAYLOAD;
                res.packet_kind = kind_reg;
                left_next       = left_dec;
                if (left_dec == 16'd0)
                begin
                    res.end_of_packet = 1'b1;
                    phase_next        = PH_IDLE;
                end
            end
            default:
            begin
                phase_next   = PH_IDLE;
                hdr_idx_next = 3'd0;
                case (rx_byte)
                    IND_EVENT:
                    begin
                        kind_next       = KIND_EVENT;
                        res.packet_kind = KIND_EVENT;
                        phase_next      = PH_HEADER;
                    end
                    IND_ACL:
                    begin
                        kind_next       = KIND_ACL;
                        res.packet_kind = KIND_ACL;
                        phase_next      = PH_HEADER;
                    end
                    IND_SCO:
                    begin
                        kind_next       = KIND_SCO;
                        res.packet_kind = KIND_SCO;
                        phase_next      = PH_HEADER;
                    end
                    default:
                    begin
                        res.status = STATUS_BAD_IND;
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            kind_reg    <= KIND_EVENT;
            hdr_idx_reg <= 3'd0;
            left_reg    <= 16'd0;
            len_lo_reg  <= 8'd0;
            max_reg     <= MAX_PACKET_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                max_reg <= cfg_data;
            end
            if (accept)
            begin
                phase_reg   <= phase_next;
                kind_reg    <= kind_next;
                hdr_idx_reg <= hdr_idx_next;
                left_reg    <= left_next;
                len_lo_reg  <= len_lo_next;
            end
        end
    end

endmodule

/* src/hpd_queue.sv */
// ----------------------------------------------------------------------------
// hpd_queue
// short result queue between the framing logic and the output channel
// ----------------------------------------------------------------------------
module hpd_queue
    import hpd_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push_valid,
    output logic    push_ready,
    input  result_t push_data,
    output logic    pop_valid,
    input  logic    pop_ready,
    output result_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    result_t          mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* src/hci_h4_packet_deframer_top.sv */
// ----------------------------------------------------------------------------
// hci_h4_packet_deframer_top
// frames hci h4 packets from a received byte stream, one result per word
// a word accepted at the input is written into the result queue and offered on the output from its head
// throughput: one word per cycle while the result queue has room, set by the framing state machine
// the result queue absorbs output stalls; input ready drops only when it is full
// reset: async active low, waits for an indicator, buffer limit 1024, queue empty
// ----------------------------------------------------------------------------
module hci_h4_packet_deframer_top
    import hpd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic      clk,
    input  logic      rst_n,
    hpd_in_if.sink    in_ch,
    hpd_out_if.source out_ch,
    hpd_cfg_if.sink   cfg_ch
);

    logic    push_valid;
    logic    push_ready;
    result_t push_data;
    result_t pop_data;

    assign cfg_ch.ready = 1'b1;
    assign in_ch.ready  = push_ready;

    hpd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .rx_byte    (in_ch.rx_byte),
        .cfg_we     (cfg_ch.valid),
        .cfg_data   (cfg_ch.max_packet_bytes),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    hpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (out_ch.valid),
        .pop_ready  (out_ch.ready),
        .pop_data   (pop_data)
    );

    assign out_ch.data_byte     = pop_data.data_byte;
    assign out_ch.byte_role     = pop_data.byte_role;
    assign out_ch.packet_kind   = pop_data.packet_kind;
    assign out_ch.end_of_packet = pop_data.end_of_packet;
    assign out_ch.status        = pop_data.status;

endmodule
